### rtl/nmea_rmc_pkg.sv
// Package for the RMC sentence parser: character codes, field numbers,
// status codes, stage payload types and small decode functions.
// No dependencies.
package nmea_rmc_pkg;

	// Sentence characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_R      = 8'h52;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_V      = 8'h56;

	// Positions after '$' that hold the type letters
	localparam logic [2:0] POS_TYPE_R   = 3'd3;
	localparam logic [2:0] POS_TYPE_M   = 3'd4;
	localparam logic [2:0] POS_TYPE_C   = 3'd5;
	localparam logic [2:0] POS_MAX      = 3'd7;
	localparam logic [2:0] FIELD_CHARS  = 3'd6;
	localparam logic [3:0] COMMA_MAX    = 4'd15;

	// Comma-separated field numbers
	localparam logic [3:0] FIELD_TIME   = 4'd1;
	localparam logic [3:0] FIELD_STATUS = 4'd2;
	localparam logic [3:0] FIELD_DATE   = 4'd9;

	// Calendar constants
	localparam logic [11:0] BASE_YEAR     = 12'd2000;
	localparam logic [7:0]  YEARS_TO_BASE = 8'd30;   // 2000 - 1970
	localparam logic [7:0]  LEAP_OFFSET   = 8'd31;   // 2000 - 1969
	localparam logic [16:0] DAYS_PER_YEAR = 17'd365;
	localparam logic [31:0] SEC_PER_DAY   = 32'd86400;
	localparam logic [18:0] SEC_PER_HOUR  = 19'd3600;
	localparam logic [18:0] SEC_PER_MIN   = 19'd60;
	localparam logic [6:0]  MONTH_FEB     = 7'd2;
	localparam logic [6:0]  MONTH_DEC     = 7'd12;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_CHECKSUM   = 3'd1,
		ST_NOT_RMC    = 3'd2,
		ST_VOID_FIX   = 3'd3,
		ST_BAD_STATUS = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		HEX_IDLE = 2'd0,
		HEX_HIGH = 2'd1,
		HEX_LOW  = 2'd2
	} hex_pos_t;

	// Per-sentence state as it stands after the final character
	typedef struct packed {
		logic        seen_dollar;
		logic        seen_star;
		logic [7:0]  running_xor;
		logic [7:0]  received_checksum;
		logic [2:0]  position_after_dollar;
		logic        type_matches;
		logic [7:0]  status_char;
		logic [23:0] time_digits;
		logic [23:0] date_digits;
	} snap_t;

	// Decoded sentence, ready for final assembly
	typedef struct packed {
		status_t     status;
		logic [6:0]  hour;
		logic [6:0]  minute;
		logic [6:0]  second;
		logic [6:0]  day;
		logic [6:0]  month;
		logic [11:0] year;
		logic        month_ok;
		logic [18:0] day_seconds;
		logic [31:0] day_start;
	} epoch_t;

	function automatic logic [3:0] hex_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'h0;
		case (c) inside
			[8'h30:8'h39]: v = c[3:0];
			[8'h41:8'h46],
			[8'h61:8'h66]: v = 4'(c[3:0] + 4'd9);
			default:       v = 4'h0;
		endcase
		return v;
	endfunction

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [3:0] v;
		v = 4'h0;
		case (c) inside
			[8'h30:8'h39]: v = c[3:0];
			default:       v = 4'h0;
		endcase
		return v;
	endfunction

	// First nibble is the tens digit, second the units digit
	function automatic logic [6:0] two_digits(input logic [7:0] pair);
		return 7'(7'(pair[3:0]) * 7'd10 + 7'(pair[7:4]));
	endfunction

	function automatic logic [8:0] days_before_month(input logic [6:0] month);
		logic [8:0] d;
		d = 9'd0;
		case (month)
			7'd1:    d = 9'd0;
			7'd2:    d = 9'd31;
			7'd3:    d = 9'd59;
			7'd4:    d = 9'd90;
			7'd5:    d = 9'd120;
			7'd6:    d = 9'd151;
			7'd7:    d = 9'd181;
			7'd8:    d = 9'd212;
			7'd9:    d = 9'd243;
			7'd10:   d = 9'd273;
			7'd11:   d = 9'd304;
			7'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

### rtl/nmea_rmc_char_if.sv
// Character channel of the RMC sentence parser: valid/ready plus one
// character and its end-of-sentence mark. No dependencies.
interface nmea_rmc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_sentence;

	modport source (output valid, output char_in, output end_of_sentence, input ready);
	modport sink   (input valid, input char_in, input end_of_sentence, output ready);
endinterface

### rtl/nmea_rmc_result_if.sv
// Result channel of the RMC sentence parser: valid/ready plus the decoded
// status, time, date and Unix seconds. No dependencies.
interface nmea_rmc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        fix_valid;
	logic [6:0]  hour;
	logic [6:0]  minute;
	logic [6:0]  second;
	logic [6:0]  day;
	logic [6:0]  month;
	logic [11:0] year;
	logic [31:0] unix_seconds;

	modport source (output valid, output status, output fix_valid, output hour,
		output minute, output second, output day, output month, output year,
		output unix_seconds, input ready);
	modport sink   (input valid, input status, input fix_valid, input hour,
		input minute, input second, input day, input month, input year,
		input unix_seconds, output ready);
endinterface

### rtl/nmea_rmc_scan.sv
// Per-character sentence scanner: checksum, type check, comma counting and
// field capture. Depends on nmea_rmc_pkg.
module nmea_rmc_scan
	import nmea_rmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] char_in,
	input  logic       end_of_sentence,
	output snap_t      snap
);

	logic        seen_dollar_q, seen_dollar_n;
	logic        seen_star_q, seen_star_n;
	logic        type_q, type_n;
	logic [7:0]  xor_q, xor_n;
	logic [7:0]  rc_q, rc_n;
	logic [7:0]  stat_q, stat_n;
	hex_pos_t    hex_q, hex_n;
	logic [2:0]  pos_q, pos_n;
	logic [2:0]  fci_q, fci_n;
	logic [3:0]  comma_q, comma_n;
	logic [23:0] time_q, time_n;
	logic [23:0] date_q, date_n;
	logic [3:0]  dig;

	// Work out the state after this character
	always_comb begin
		seen_dollar_n = seen_dollar_q;
		seen_star_n   = seen_star_q;
		type_n        = type_q;
		xor_n         = xor_q;
		rc_n          = rc_q;
		stat_n        = stat_q;
		hex_n         = hex_q;
		pos_n         = pos_q;
		fci_n         = fci_q;
		comma_n       = comma_q;
		time_n        = time_q;
		date_n        = date_q;
		dig           = digit_value(char_in);

		if (char_in == CH_STAR) seen_star_n = 1'b1;
		if (seen_dollar_q && !seen_star_n) xor_n = xor_q ^ char_in;

		// Received checksum: restart on '*', then high and low digit
		if (char_in == CH_STAR && seen_dollar_q) begin
			rc_n  = 8'h00;
			hex_n = HEX_HIGH;
		end else if (hex_q == HEX_HIGH) begin
			rc_n  = {hex_value(char_in), 4'h0};
			hex_n = HEX_LOW;
		end else if (hex_q == HEX_LOW) begin
			rc_n  = rc_q | {4'h0, hex_value(char_in)};
			hex_n = HEX_IDLE;
		end

		if (!seen_dollar_q) begin
			if (char_in == CH_DOLLAR) seen_dollar_n = 1'b1;
		end else begin
			if (pos_q != POS_MAX) pos_n = 3'(pos_q + 3'd1);
			if ((pos_n == POS_TYPE_R && char_in != CH_R) ||
				(pos_n == POS_TYPE_M && char_in != CH_M) ||
				(pos_n == POS_TYPE_C && char_in != CH_C))
				type_n = 1'b0;

			if (char_in == CH_COMMA) begin
				if (comma_q != COMMA_MAX) comma_n = 4'(comma_q + 4'd1);
				fci_n = 3'd0;
			end else if (fci_q < FIELD_CHARS) begin
				for (int i = 0; i < 6; i++) begin
					if (fci_q == 3'(i)) begin
						if (comma_q == FIELD_TIME) time_n[i*4 +: 4] = time_q[i*4 +: 4] | dig;
						if (comma_q == FIELD_DATE) date_n[i*4 +: 4] = date_q[i*4 +: 4] | dig;
					end
				end
				if (comma_q == FIELD_STATUS && fci_q == 3'd0) stat_n = char_in;
				fci_n = 3'(fci_q + 3'd1);
			end
		end
	end

	// Hand the finished sentence on
	always_comb begin
		snap.seen_dollar           = seen_dollar_n;
		snap.seen_star             = seen_star_n;
		snap.running_xor           = xor_n;
		snap.received_checksum     = rc_n;
		snap.position_after_dollar = pos_n;
		snap.type_matches          = type_n;
		snap.status_char           = stat_n;
		snap.time_digits           = time_n;
		snap.date_digits           = date_n;
	end

	// Advance on each transaction, clear after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_dollar_q <= 1'b0;
			seen_star_q   <= 1'b0;
			type_q        <= 1'b1;
			xor_q         <= 8'h00;
			rc_q          <= 8'h00;
			stat_q        <= 8'h00;
			hex_q         <= HEX_IDLE;
			pos_q         <= 3'd0;
			fci_q         <= 3'd0;
			comma_q       <= 4'd0;
			time_q        <= 24'h0;
			date_q        <= 24'h0;
		end else if (take) begin
			if (end_of_sentence) begin
				seen_dollar_q <= 1'b0;
				seen_star_q   <= 1'b0;
				type_q        <= 1'b1;
				xor_q         <= 8'h00;
				rc_q          <= 8'h00;
				stat_q        <= 8'h00;
				hex_q         <= HEX_IDLE;
				pos_q         <= 3'd0;
				fci_q         <= 3'd0;
				comma_q       <= 4'd0;
				time_q        <= 24'h0;
				date_q        <= 24'h0;
			end else begin
				seen_dollar_q <= seen_dollar_n;
				seen_star_q   <= seen_star_n;
				type_q        <= type_n;
				xor_q         <= xor_n;
				rc_q          <= rc_n;
				stat_q        <= stat_n;
				hex_q         <= hex_n;
				pos_q         <= pos_n;
				fci_q         <= fci_n;
				comma_q       <= comma_n;
				time_q        <= time_n;
				date_q        <= date_n;
			end
		end
	end

endmodule

### rtl/nmea_rmc_epoch.sv
// Four-stage pipeline that grades a finished sentence and works out day
// count and seconds of day. Depends on nmea_rmc_pkg.
module nmea_rmc_epoch
	import nmea_rmc_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   in_valid,
	output logic   in_ready,
	input  snap_t  in_snap,
	output logic   out_valid,
	input  logic   out_ready,
	output epoch_t out_data
);

	logic        v_s1, v_s2, v_s3, v_s4;
	logic        free_s1, free_s2, free_s3, free_s4;
	snap_t       snap_s1;
	status_t     status_s2;
	logic [6:0]  hour_s2, minute_s2, second_s2, day_s2, month_s2, yr_s2;
	epoch_t      ep_s3, ep_s4;
	epoch_t      ep_scaled;
	status_t     status_c;
	logic [7:0]  yoff;
	logic [7:0]  leap_base;
	logic [16:0] day_sum;
	logic        leap_day;

	// Stages move up when the next one is empty or moving
	assign free_s4  = !v_s4 || out_ready;
	assign free_s3  = !v_s3 || free_s4;
	assign free_s2  = !v_s2 || free_s3;
	assign free_s1  = !v_s1 || free_s2;
	assign in_ready = free_s1;
	assign out_valid = v_s4;
	assign out_data  = ep_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (free_s1) v_s1 <= in_valid;
			if (free_s2) v_s2 <= v_s1;
			if (free_s3) v_s3 <= v_s2;
			if (free_s4) v_s4 <= v_s3;
		end
	end

	// Grade the sentence
	always_comb begin
		if ((!snap_s1.seen_dollar && !snap_s1.seen_star) ||
			snap_s1.received_checksum != snap_s1.running_xor)
			status_c = ST_CHECKSUM;
		else if (!snap_s1.seen_dollar || snap_s1.position_after_dollar < POS_TYPE_C ||
			!snap_s1.type_matches)
			status_c = ST_NOT_RMC;
		else if (snap_s1.status_char == CH_V)
			status_c = ST_VOID_FIX;
		else if (snap_s1.status_char != CH_A)
			status_c = ST_BAD_STATUS;
		else
			status_c = ST_OK;
	end

	// Day count since 1970 and seconds of the day
	always_comb begin
		yoff      = 8'(8'(yr_s2) + YEARS_TO_BASE);
		leap_base = 8'(8'(yr_s2) + LEAP_OFFSET);
		leap_day  = (month_s2 > MONTH_FEB) && (yr_s2[1:0] == 2'b00);
		day_sum   = 17'(17'(yoff) * DAYS_PER_YEAR + 17'(leap_base[7:2]) +
			17'(days_before_month(month_s2)) + 17'(leap_day) + 17'(day_s2));
	end

	// Capture the snapshot
	always_ff @(posedge clk) begin
		if (free_s1 && in_valid) snap_s1 <= in_snap;
	end

	// Decode status and digits
	always_ff @(posedge clk) begin
		if (free_s2 && v_s1) begin
			status_s2 <= status_c;
			hour_s2   <= two_digits(snap_s1.time_digits[7:0]);
			minute_s2 <= two_digits(snap_s1.time_digits[15:8]);
			second_s2 <= two_digits(snap_s1.time_digits[23:16]);
			day_s2    <= two_digits(snap_s1.date_digits[7:0]);
			month_s2  <= two_digits(snap_s1.date_digits[15:8]);
			yr_s2     <= two_digits(snap_s1.date_digits[23:16]);
		end
	end

	// Day count; a zero day steps back one day, wrapping
	always_ff @(posedge clk) begin
		if (free_s3 && v_s2) begin
			ep_s3.status      <= status_s2;
			ep_s3.hour        <= hour_s2;
			ep_s3.minute      <= minute_s2;
			ep_s3.second      <= second_s2;
			ep_s3.day         <= day_s2;
			ep_s3.month       <= month_s2;
			ep_s3.year        <= 12'(BASE_YEAR + 12'(yr_s2));
			ep_s3.month_ok    <= (month_s2 != 7'd0) && (month_s2 <= MONTH_DEC);
			ep_s3.day_seconds <= 19'(19'(second_s2) + 19'(minute_s2) * SEC_PER_MIN +
				19'(hour_s2) * SEC_PER_HOUR);
			ep_s3.day_start   <= 32'(32'(day_sum) - 32'd1);
		end
	end

	// Scale days to seconds, modulo 2^32
	always_comb begin
		ep_scaled           = ep_s3;
		ep_scaled.day_start = 32'(ep_s3.day_start * SEC_PER_DAY);
	end

	always_ff @(posedge clk) begin
		if (free_s4 && v_s3) ep_s4 <= ep_scaled;
	end

endmodule

### rtl/nmea_rmc_sentence_parser.sv
// Top level of the RMC sentence parser: character scanner, result pipeline
// and the output register that holds the last good fix.
// Depends on nmea_rmc_pkg, nmea_rmc_char_if, nmea_rmc_result_if,
// nmea_rmc_scan and nmea_rmc_epoch.
//
// Takes one character per clock cycle while ready is high and gives one
// result per sentence, on its final character. The result passes through
// four pipeline stages (snapshot capture, grade and digit decode, day
// count, scaling by seconds per day) and the output register. Characters
// keep flowing while a result waits; ready falls only when all four stages
// and the output register hold results that have not been taken. A failed
// sentence reports the time, date and Unix seconds of the last good one.
module nmea_rmc_sentence_parser
	import nmea_rmc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	nmea_rmc_char_if.sink     chars,
	nmea_rmc_result_if.source report
);

	snap_t       snap;
	logic        pipe_ready;
	logic        pipe_valid;
	logic        out_free;
	epoch_t      ep;
	logic        take;
	logic        out_v_q;
	logic        fix_q;
	logic [2:0]  status_q;
	logic [6:0]  hour_q, minute_q, second_q, day_q, month_q;
	logic [11:0] year_q;
	logic [31:0] unix_q;
	logic [31:0] unix_new;

	assign chars.ready = pipe_ready;
	assign take        = chars.valid && pipe_ready;
	assign out_free    = !out_v_q || report.ready;

	nmea_rmc_scan u_scan (
		.clk             (clk),
		.arst_n          (arst_n),
		.take            (take),
		.char_in         (chars.char_in),
		.end_of_sentence (chars.end_of_sentence),
		.snap            (snap)
	);

	nmea_rmc_epoch u_epoch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid && chars.end_of_sentence),
		.in_ready  (pipe_ready),
		.in_snap   (snap),
		.out_valid (pipe_valid),
		.out_ready (out_free),
		.out_data  (ep)
	);

	// Final seconds; out-of-range month gives zero
	assign unix_new = ep.month_ok ? 32'(ep.day_start + 32'(ep.day_seconds)) : 32'd0;

	// Output register; good results replace the held fix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			fix_q    <= 1'b0;
			status_q <= ST_OK;
			hour_q   <= 7'd0;
			minute_q <= 7'd0;
			second_q <= 7'd0;
			day_q    <= 7'd0;
			month_q  <= 7'd0;
			year_q   <= BASE_YEAR;
			unix_q   <= 32'd0;
		end else if (out_free) begin
			out_v_q <= pipe_valid;
			if (pipe_valid) begin
				status_q <= ep.status;
				if (ep.status == ST_VOID_FIX) fix_q <= 1'b0;
				if (ep.status == ST_OK) begin
					fix_q    <= 1'b1;
					hour_q   <= ep.hour;
					minute_q <= ep.minute;
					second_q <= ep.second;
					day_q    <= ep.day;
					month_q  <= ep.month;
					year_q   <= ep.year;
					unix_q   <= unix_new;
				end
			end
		end
	end

	assign report.valid        = out_v_q;
	assign report.status       = status_q;
	assign report.fix_valid    = fix_q;
	assign report.hour         = hour_q;
	assign report.minute       = minute_q;
	assign report.second       = second_q;
	assign report.day          = day_q;
	assign report.month        = month_q;
	assign report.year         = year_q;
	assign report.unix_seconds = unix_q;

endmodule

### tb/nmea_rmc_fix_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the RMC sentence parser: follows every character transaction,
// predicts the report of each sentence and compares it field by field.
// Depends on nmea_rmc_pkg, nmea_rmc_char_if and nmea_rmc_result_if.
module nmea_rmc_fix_checker
	import nmea_rmc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	nmea_rmc_char_if   chars,
	nmea_rmc_result_if results,
	output int         fail_count,
	output int         pending
);

	typedef struct {
		status_t     status;
		logic        fix_valid;
		logic [6:0]  hour, minute, second, day, month;
		logic [11:0] year;
		logic [31:0] unix_seconds;
	} fix_report_t;

	localparam int unsigned EPOCH_YEAR = 1970;
	localparam int unsigned MONTH_START_DAY [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	fix_report_t expected_fixes[$];
	fix_report_t last_good;
	fix_report_t closed_fix;
	fix_report_t want;

	// Sentence scan state
	logic        dollar_seen, star_seen, rmc_ok, fix_held;
	logic [7:0]  xor_sum, sum_field, status_letter;
	hex_pos_t    hex_pos;
	logic [2:0]  pos_after;
	logic [3:0]  commas;
	logic [2:0]  field_idx;
	logic [23:0] time_nibbles, date_nibbles;

	function automatic logic [3:0] hex_nibble(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return c[3:0];
		if (c >= "A" && c <= "F")
			return 4'(c - "A" + 8'd10);
		if (c >= "a" && c <= "f")
			return 4'(c - "a" + 8'd10);
		return 4'h0;
	endfunction

	// Tens digit sits in the lower nibble of each byte
	function automatic logic [6:0] pair_value(input logic [23:0] nib, input int pair);
		int unsigned tens, units;
		tens  = nib[pair*8 +: 4];
		units = nib[pair*8+4 +: 4];
		return 7'(tens * 10 + units);
	endfunction

	// Seconds since 1970, wrapping at 32 bits; a bad month gives zero
	function automatic logic [31:0] epoch_seconds(input int unsigned y, input int unsigned mo,
			input int unsigned d, input int unsigned h, input int unsigned mi,
			input int unsigned s);
		int unsigned days;
		if (mo < 1 || mo > MONTH_DEC)
			return 32'd0;
		days = 365 * (y - EPOCH_YEAR) + (y - EPOCH_YEAR + 1) / 4 + MONTH_START_DAY[mo - 1];
		if (mo > MONTH_FEB && y % 4 == 0)
			days++;
		return days * 86400 + (d - 1) * 86400 + s + mi * 60 + h * 3600;
	endfunction

	task automatic restart_sentence();
		dollar_seen   = 1'b0;
		star_seen     = 1'b0;
		rmc_ok        = 1'b1;
		xor_sum       = 8'h00;
		sum_field     = 8'h00;
		status_letter = 8'h00;
		hex_pos       = HEX_IDLE;
		pos_after     = '0;
		commas        = '0;
		field_idx     = '0;
		time_nibbles  = '0;
		date_nibbles  = '0;
	endtask

	task automatic take_char(input logic [7:0] c);
		logic       before_dollar;
		logic [3:0] dig;
		before_dollar = !dollar_seen;
		if (c == CH_STAR)
			star_seen = 1'b1;
		if (dollar_seen && !star_seen)
			xor_sum ^= c;

		// Track the two checksum digits after a star
		if (c == CH_STAR && dollar_seen) begin
			sum_field = 8'h00;
			hex_pos   = HEX_HIGH;
		end else if (hex_pos == HEX_HIGH) begin
			sum_field = {hex_nibble(c), 4'h0};
			hex_pos   = HEX_LOW;
		end else if (hex_pos == HEX_LOW) begin
			sum_field[3:0] = hex_nibble(c);
			hex_pos        = HEX_IDLE;
		end

		if (before_dollar) begin
			if (c == CH_DOLLAR)
				dollar_seen = 1'b1;
		end else begin
			if (pos_after < POS_MAX)
				pos_after++;
			if ((pos_after == POS_TYPE_R && c != CH_R) ||
					(pos_after == POS_TYPE_M && c != CH_M) ||
					(pos_after == POS_TYPE_C && c != CH_C))
				rmc_ok = 1'b0;

			// Count fields; capture time, status and date characters
			if (c == CH_COMMA) begin
				if (commas < COMMA_MAX)
					commas++;
				field_idx = '0;
			end else if (field_idx < FIELD_CHARS) begin
				dig = (c >= "0" && c <= "9") ? c[3:0] : 4'h0;
				if (commas == FIELD_TIME)
					time_nibbles[field_idx*4 +: 4] = time_nibbles[field_idx*4 +: 4] | dig;
				if (commas == FIELD_DATE)
					date_nibbles[field_idx*4 +: 4] = date_nibbles[field_idx*4 +: 4] | dig;
				if (commas == FIELD_STATUS && field_idx == 0)
					status_letter = c;
				field_idx++;
			end
		end
	endtask

	task automatic close_sentence(output fix_report_t r);
		status_t st;
		if ((!dollar_seen && !star_seen) || sum_field != xor_sum) begin
			st = ST_CHECKSUM;
		end else if (!dollar_seen || pos_after < POS_TYPE_C || !rmc_ok) begin
			st = ST_NOT_RMC;
		end else if (status_letter == CH_V) begin
			st       = ST_VOID_FIX;
			fix_held = 1'b0;
		end else if (status_letter != CH_A) begin
			st = ST_BAD_STATUS;
		end else begin
			st                  = ST_OK;
			fix_held            = 1'b1;
			last_good.hour      = pair_value(time_nibbles, 0);
			last_good.minute    = pair_value(time_nibbles, 1);
			last_good.second    = pair_value(time_nibbles, 2);
			last_good.day       = pair_value(date_nibbles, 0);
			last_good.month     = pair_value(date_nibbles, 1);
			last_good.year      = 12'(pair_value(date_nibbles, 2)) + BASE_YEAR;
			last_good.unix_seconds = epoch_seconds(last_good.year, last_good.month,
				last_good.day, last_good.hour, last_good.minute, last_good.second);
		end
		r           = last_good;
		r.status    = st;
		r.fix_valid = fix_held;
	endtask

	task automatic flag_mismatch(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] exp_v);
		if (got !== exp_v)
			flag_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp_v));
	endtask

	// Predict on each character transaction, compare on each result transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_sentence();
			fix_held               = 1'b0;
			last_good.status       = ST_OK;
			last_good.fix_valid    = 1'b0;
			last_good.hour         = '0;
			last_good.minute       = '0;
			last_good.second       = '0;
			last_good.day          = '0;
			last_good.month        = '0;
			last_good.year         = BASE_YEAR;
			last_good.unix_seconds = '0;
			expected_fixes.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (chars.valid && chars.ready) begin
				take_char(chars.char_in);
				if (chars.end_of_sentence) begin
					close_sentence(closed_fix);
					expected_fixes.push_back(closed_fix);
					restart_sentence();
				end
			end
			if (results.valid && results.ready) begin
				if (expected_fixes.size() == 0) begin
					flag_mismatch("result with no sentence outstanding");
				end else begin
					want = expected_fixes.pop_front();
					check_field("status", results.status, want.status);
					check_field("fix_valid", results.fix_valid, want.fix_valid);
					check_field("hour", results.hour, want.hour);
					check_field("minute", results.minute, want.minute);
					check_field("second", results.second, want.second);
					check_field("day", results.day, want.day);
					check_field("month", results.month, want.month);
					check_field("year", results.year, want.year);
					check_field("unix_seconds", results.unix_seconds, want.unix_seconds);
				end
			end
			pending = expected_fixes.size();
		end
	end

endmodule

### tb/tb_nmea_rmc_sentence_parser.sv
`timescale 1ns / 100ps
// Testbench top for the RMC sentence parser: clock, reset, sentence stimulus
// and result back-pressure; nmea_rmc_fix_checker does the prediction.
// Depends on nmea_rmc_pkg, both channel interfaces and the parser RTL.
module tb_nmea_rmc_sentence_parser;
	import nmea_rmc_pkg::*;

	localparam int CHAR_TARGET     = 1450;
	localparam int SENTENCE_TARGET = 60;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int BURST_SENTENCES = 40;
	localparam int DRAIN_CYCLES    = 20;
	localparam int CYCLE_LIMIT     = 400000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   cycle_count    = 0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   chars_sent     = 0;
	int   sentences_sent = 0;
	int   hold_left      = 0;
	bit   hold_off_req   = 1'b0;

	nmea_rmc_char_if   char_ch();
	nmea_rmc_result_if fix_ch();

	nmea_rmc_sentence_parser DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (char_ch),
		.report (fix_ch)
	);

	nmea_rmc_fix_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.chars      (char_ch),
		.results    (fix_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("nmea_rmc_sentence_parser: mismatch");
			$finish;
		end
	end

	// Result side: random stalls, or a long hold-off on request
	initial begin
		fix_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				fix_ch.ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left    = HOLD_OFF_CYCLES;
				fix_ch.ready <= 1'b0;
			end else begin
				fix_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			char_ch.valid <= 1'b0;
			@(posedge clk);
		end
		char_ch.valid           <= 1'b1;
		char_ch.char_in         <= c;
		char_ch.end_of_sentence <= eos;
		@(posedge clk);
		while (!char_ch.ready)
			@(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
		sentences_sent++;
	endtask

	task automatic send_noise(input int n, input int lo, input int hi);
		for (int i = 0; i < n; i++)
			send_char(8'($urandom_range(hi, lo)), i == n - 1);
		sentences_sent++;
	endtask

	// Hold the input idle until every report has come back
	task automatic wait_drained();
		char_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] body_xor(input string body);
		logic [7:0] x;
		x = 8'h00;
		for (int i = 0; i < body.len(); i++)
			x ^= body[i];
		return x;
	endfunction

	function automatic string good_line(input string body);
		return {"$", body, "*", $sformatf("%02X", body_xor(body))};
	endfunction

	// Mostly a plausible value, sometimes anything up to 99
	function automatic int two_digit(input int lo, input int hi);
		if ($urandom_range(9) == 0)
			return $urandom_range(99);
		return $urandom_range(hi, lo);
	endfunction

	task automatic send_random_sentence();
		string tm, st, dt, mid, tail, id, body, prefix, sum, line;
		logic [7:0] x;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			send_noise($urandom_range(12, 1), 1, 255);
		end else begin
			tm = $sformatf("%02d%02d%02d", two_digit(0, 23), two_digit(0, 59),
				two_digit(0, 59));
			if ($urandom_range(3) == 0)
				tm = {tm, $sformatf(".%02d", $urandom_range(99))};
			if ($urandom_range(19) == 0)
				tm[$urandom_range(tm.len() - 1)] = "x";

			pick = $urandom_range(99);
			if (pick < 80)
				st = "A";
			else if (pick < 90)
				st = "V";
			else if (pick < 95)
				st = "";
			else
				st = "X";

			dt = $sformatf("%02d%02d%02d", two_digit(1, 31), two_digit(1, 12),
				$urandom_range(99));
			if ($urandom_range(2) == 0)
				mid = ",,,,,,,";
			else
				mid = $sformatf(",%04d.%03d,N,%05d.%03d,E,%03d.%01d,%03d.%01d,",
					$urandom_range(9999), $urandom_range(999), $urandom_range(99999),
					$urandom_range(999), $urandom_range(999), $urandom_range(9),
					$urandom_range(359), $urandom_range(9));
			tail = $urandom_range(1) ? ",003.1,W" : "";

			id = $urandom_range(1) ? "GPRMC" : "GNRMC";
			if ($urandom_range(19) == 0)
				id[$urandom_range(4, 2)] = "Q";
			body   = {id, ",", tm, ",", st, mid, dt, tail};
			prefix = ($urandom_range(9) == 0) ? "\r\nab" : "";
			x      = body_xor(body);

			// Checksum: mostly right, else wrong, missing, short, non-hex or doubled
			pick = $urandom_range(99);
			if (pick < 70)
				sum = $sformatf("%02X", x);
			else if (pick < 80)
				sum = $sformatf("%02x", x);
			else if (pick < 86)
				sum = $sformatf("%02X", x ^ 8'($urandom_range(255, 1)));
			else if (pick < 89)
				sum = "";
			else if (pick < 92)
				sum = $sformatf("%01X", x[7:4]);
			else if (pick < 96)
				sum = "Zq";
			else
				sum = $sformatf("%02X*%02X", $urandom_range(255), x);

			line = {prefix, "$", body, "*", sum};
			if ($urandom_range(24) == 0)
				line = line.substr(0, $urandom_range(line.len() - 1));
			send_text(line);
		end
	endtask

	initial begin
		int phase, last_phase, random_sent;
		string body;

		arst_n                  = 1'b0;
		char_ch.valid           = 1'b0;
		char_ch.char_in         = 8'h20;
		char_ch.end_of_sentence = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sentences
		send_text(good_line("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W"));
		send_text(good_line("GPRMC,235959.99,V,,,,,,,311299,,"));
		send_text(good_line("GPRMC,000000,,,,,,,,010100"));
		send_text(good_line("GPRMC,101010,X,,,,,,,151015"));
		send_text(good_line("GPGGA,123519,A,,,,,,,230394"));
		send_text("hello");
		send_text("*$GPRMC,010203,A,,,,,,,290224");
		body = "GPRMC,120000,A,,,,,,,010324";
		send_text({"$", body, "*5A*", $sformatf("%02X", body_xor(body))});
		send_text({"$", body, "*"});
		send_text({"$", body, "*G?"});
		body = "GNRMC,225446,A,4916.45,N,12311.12,W,000.5,054.7,191194,020.3,E";
		send_text({"$", body, "*", $sformatf("%02x", body_xor(body))});
		send_text(good_line("GP"));
		send_text("$");
		send_text("$GPRMC");
		send_text(good_line("GPRMC,080910,A,,,,,,,150070"));
		send_text(good_line("GPRMC,080910,A,,,,,,,011399"));
		send_text(good_line("GPRMC,000001,A,,,,,,,000105"));
		send_text(good_line("GPRMC,999999,A,,,,,,,991299"));
		send_text(good_line("GPRMC,1a:5b9,A,,,,,,,010170"));
		send_text(good_line("GPRMC,1234567890,A,,,,,,,0102030405,,,,,,,,,,,,,"));
		send_text(good_line("GNRMC,000000,A,,,,,,,010100"));
		send_noise(8, 128, 255);
		send_noise(1, 1, 1);
		wait_drained();

		// Hold off results and offer a burst of short sentences so that input stalls
		hold_off_req = 1'b1;
		repeat (BURST_SENTENCES)
			send_noise($urandom_range(3, 1), 1, 255);
		wait_drained();

		// Random sentences, cycling the idle pattern every two sentences
		last_phase  = -1;
		random_sent = 0;
		while (chars_sent < CHAR_TARGET || sentences_sent < SENTENCE_TARGET) begin
			phase = (random_sent / 2) % 4;
			if (phase != last_phase) begin
				wait_drained();
				case (phase)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
					default: begin send_idle_pct = 19; recv_stall_pct = 19; end
				endcase
				last_phase = phase;
			end
			send_random_sentence();
			random_sent++;
		end

		// Drain and give the verdict
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("nmea_rmc_sentence_parser: match");
		else
			$display("nmea_rmc_sentence_parser: mismatch");
		$finish;
	end

endmodule
